[hdl/packet_duplicate_cache_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the packet duplicate cache
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef PACKET_DUPLICATE_CACHE_ASSERT_SVH
`define PACKET_DUPLICATE_CACHE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PDC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/pdc_pkg.sv]
// ----------------------------------------------------------------------------
// Packet duplicate cache package
// Types, codes and constants shared by the duplicate cache RTL.
// ----------------------------------------------------------------------------
package pdc_pkg;

	localparam int unsigned CACHE_ENTRIES_DEF = 32;

	// Lifetime is configured in seconds, held and compared in milliseconds.
	localparam logic [9:0] MS_PER_SECOND = 10'd1000;
	// 65535 s * 1000 fits in 26 bits.
	localparam int unsigned TTL_W = 26;

	localparam logic [1:0] ACT_CHECK = 2'd0;
	localparam logic [1:0] ACT_MARK  = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	localparam logic [1:0] VERDICT_NEW     = 2'd0;
	localparam logic [1:0] VERDICT_SEEN    = 2'd1;
	localparam logic [1:0] VERDICT_UPGRADE = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] source_node;
		logic [31:0] packet_ident;
		logic [2:0]  hops_left;
		logic        upgrade_allowed;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  verdict;
		logic        expired_match;
		logic        entry_found;
		logic        was_relayed;
		logic [31:0] relay_gap_ms;
		logic [31:0] duplicate_total;
	} out_item_t;

	typedef struct packed {
		logic [31:0] source;
		logic [31:0] ident;
		logic [31:0] time_ms;
		logic [2:0]  hops;
		logic        relayed;
		logic [31:0] relay_time;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

[hdl/packet_duplicate_cache.sv]
// ----------------------------------------------------------------------------
// Packet duplicate cache
// Slots are read in index order through the registered read port and compared;
// the scan ends early on a hit, then a finishing step updates the cache and
// registers the result for the done strobe. One transaction at a time: start is
// taken again in the done cycle. The single read port, one slot a cycle, sets the pace.
// Reset clears valid bits, ring head, duplicate count and lifetime; no sweep.
// ----------------------------------------------------------------------------
`include "packet_duplicate_cache_assert.svh"

module packet_duplicate_cache import pdc_pkg::*; #(
	parameter int unsigned CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    item,
	output logic        done,
	output out_item_t   result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	// Slot index width, and a scan counter wide enough to hold the entry count.
	localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(CACHE_ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);
	localparam logic [CNT_W-1:0] NUM_ENTRIES = CNT_W'(CACHE_ENTRIES);

	// Sequencer and scan control.
	state_t             state_q, state_d;
	logic [CNT_W-1:0]   scan_q;
	logic               cmp_vld_s1;
	logic [IDX_W-1:0]   cmp_idx_s1;
	entry_t             rd_data_s1;

	// Per-transaction context.
	in_item_t           item_q;
	logic               hit_q;
	logic               saw_exp_q;
	logic [IDX_W-1:0]   hit_idx_q;

	// Persistent cache state.
	logic [CACHE_ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0]   head_q;
	logic [31:0]        dup_q;
	logic [TTL_W-1:0]   ttl_q;

	// Result register.
	logic               done_q;
	out_item_t          result_q;

	// Slot memory: one write port, one registered read port.
	entry_t             mem [CACHE_ENTRIES];

	// Combinational controls.
	logic               accept;
	logic               rd_issue;
	logic               key_match;
	logic               expired_now;
	logic               hit_now;
	logic               last_cmp;
	logic [31:0]        age;
	logic               finish;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	entry_t             wr_data;
	logic               set_valid;
	logic               dup_inc;
	out_item_t          res_d;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	// The shared compare unit. It looks at the slot read in the previous cycle:
	// key equality gated by the valid bit, then the wrapping age against the
	// lifetime. Only a check honors expiry; mark and query take any valid match.
	always_comb begin
		age         = item_q.now_ms - rd_data_s1.time_ms;
		key_match   = cmp_vld_s1 && valid_q[cmp_idx_s1]
			&& (rd_data_s1.source == item_q.source_node)
			&& (rd_data_s1.ident == item_q.packet_ident);
		expired_now = (ttl_q != '0) && (age > 32'(ttl_q));
		hit_now     = key_match && !((item_q.action == ACT_CHECK) && expired_now);
		last_cmp    = cmp_vld_s1 && (cmp_idx_s1 == LAST_IDX);
	end

	// Next state, read issue and the finishing update of the cache.
	always_comb begin
		state_d   = state_q;
		rd_issue  = 1'b0;
		finish    = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = hit_idx_q;
		wr_data   = rd_data_s1;
		set_valid = 1'b0;
		dup_inc   = 1'b0;
		res_d     = '0;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// Stop reading as soon as a slot hits, so the read register keeps
				// that slot's contents for the finishing step.
				rd_issue = (scan_q < NUM_ENTRIES) && !hit_now;
				if (hit_now || last_cmp) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				finish  = 1'b1;
				state_d = ST_IDLE;
				case (item_q.action)
					ACT_CHECK: begin
						if (hit_q) begin
							if (item_q.upgrade_allowed && (item_q.hops_left > rd_data_s1.hops)) begin
								// A copy with more hops left replaces the stored hop limit.
								wr_en         = 1'b1;
								wr_data.hops  = item_q.hops_left;
								res_d.verdict = VERDICT_UPGRADE;
							end else begin
								dup_inc       = 1'b1;
								res_d.verdict = VERDICT_SEEN;
							end
						end else begin
							// New packet: overwrite the oldest slot at the ring head.
							wr_en              = 1'b1;
							wr_addr            = head_q;
							wr_data.source     = item_q.source_node;
							wr_data.ident      = item_q.packet_ident;
							wr_data.time_ms    = item_q.now_ms;
							wr_data.hops       = item_q.hops_left;
							wr_data.relayed    = 1'b0;
							wr_data.relay_time = '0;
							set_valid          = 1'b1;
							res_d.verdict      = VERDICT_NEW;
							res_d.expired_match = saw_exp_q;
						end
					end
					ACT_MARK: begin
						if (hit_q) begin
							wr_en              = 1'b1;
							wr_data.relayed    = 1'b1;
							wr_data.relay_time = item_q.now_ms;
							res_d.entry_found  = 1'b1;
						end
					end
					ACT_QUERY: begin
						if (hit_q) begin
							res_d.entry_found = 1'b1;
							if (rd_data_s1.relayed) begin
								res_d.was_relayed  = 1'b1;
								res_d.relay_gap_ms = item_q.now_ms - rd_data_s1.relay_time;
							end
						end
					end
					default: begin
						// The unused action code leaves the cache untouched.
					end
				endcase
				res_d.duplicate_total = dup_q + 32'(dup_inc);
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Scan sequencing and per-transaction flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q     <= '0;
			cmp_vld_s1 <= 1'b0;
			hit_q      <= 1'b0;
			saw_exp_q  <= 1'b0;
		end else begin
			cmp_vld_s1 <= rd_issue;
			if (accept) begin
				scan_q    <= '0;
				hit_q     <= 1'b0;
				saw_exp_q <= 1'b0;
			end else begin
				if (rd_issue) begin
					scan_q <= scan_q + CNT_W'(1);
				end
				if (hit_now) begin
					hit_q <= 1'b1;
				end
				if (key_match && (item_q.action == ACT_CHECK) && expired_now) begin
					saw_exp_q <= 1'b1;
				end
			end
		end
	end

	// Payload registers of the scan.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if (rd_issue) begin
			cmp_idx_s1 <= scan_q[IDX_W-1:0];
		end
		if (hit_now) begin
			hit_idx_q <= cmp_idx_s1;
		end
	end

	// Slot memory.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_issue) begin
			rd_data_s1 <= mem[scan_q[IDX_W-1:0]];
		end
	end

	// Cache bookkeeping, lifetime register and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			head_q  <= '0;
			dup_q   <= '0;
			ttl_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= finish;
			if (cfg_valid && cfg_ready) begin
				ttl_q <= TTL_W'(cfg_data) * TTL_W'(MS_PER_SECOND);
			end
			if (set_valid) begin
				valid_q[head_q] <= 1'b1;
				head_q <= (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
			end
			if (dup_inc) begin
				dup_q <= dup_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			result_q <= res_d;
		end
	end

	// A compare is only ever in flight while the sequencer scans.
	`PDC_ASSERT_NOW(a_cmp_in_scan, cmp_vld_s1, state_q == ST_SCAN, "compare outside scan")
	// An accepted transaction makes the block busy and cannot finish at once.
	`PDC_ASSERT_NEXT(a_accept_busy, accept, busy && !done, "accept did not start a scan")
	// The finishing step delivers exactly one result and frees the block.
	`PDC_ASSERT_NEXT(a_finish_done, state_q == ST_FINISH, done && !busy, "finish lost result")
	// A seen verdict reports the duplicate count one above its previous value.
	`PDC_ASSERT_NOW(a_dup_count, done && (result.verdict == VERDICT_SEEN),
		result.duplicate_total == ($past(dup_q) + 32'd1), "duplicate count off")

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Packet duplicate cache testbench
// Drives check, mark and query transactions into the duplicate cache and
// checks every result against a cycle-free software copy of the ring cache.
// The copy keeps its own slots, ring head, duplicate count and lifetime. It
// works out each expected result at the edge that accepts the transaction.
// Directed tests come first, followed by random traffic under several
// lifetime settings.
// ----------------------------------------------------------------------------
module testbench import pdc_pkg::*; ();

	localparam int CACHE_SLOTS = CACHE_ENTRIES_DEF;
	// The two-bit action field has one code the block does not use.
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	// Longest quiet stretch of a correct run: a full scan plus the longest gap
	// the sender inserts plus the end-of-run drain.
	localparam int unsigned STALL_LIMIT = 1000;
	localparam int KEY_POOL = 40;
	localparam int RANDOM_PER_PHASE = 320;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_item_t    item;
	logic        done;
	out_item_t   result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	packet_duplicate_cache DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Software copy of the cache. Only slots with slot_used set are ever
	// read, so the other per-slot arrays need no reset value.
	// ------------------------------------------------------------------
	bit          slot_used [CACHE_SLOTS] = '{default: 1'b0};
	logic [31:0] slot_src [CACHE_SLOTS];
	logic [31:0] slot_id [CACHE_SLOTS];
	logic [31:0] slot_seen_ms [CACHE_SLOTS];
	logic [2:0]  slot_hops [CACHE_SLOTS];
	bit          slot_relayed [CACHE_SLOTS];
	logic [31:0] slot_relay_ms [CACHE_SLOTS];
	int          ring_head = 0;
	logic [31:0] dup_count = '0;
	logic [15:0] lifetime_s = '0;

	// Expected results, oldest first.
	out_item_t   pending_verdicts[$];
	int          mismatch_count = 0;

	// First valid slot holding the key, expired or not; -1 when there is none.
	function automatic int find_entry(input logic [31:0] src, input logic [31:0] id);
		for (int i = 0; i < CACHE_SLOTS; i++) begin
			if (slot_used[i] && slot_src[i] == src && slot_id[i] == id)
				return i;
		end
		return -1;
	endfunction

	// Applies one accepted transaction to the software cache and returns the
	// result the block must produce for it.
	function automatic out_item_t predict_verdict(input in_item_t it);
		out_item_t   r;
		logic [31:0] ttl_ms;
		int          hit;
		int          s;
		bit          stale_match;
		r = '0;
		ttl_ms = 32'(lifetime_s) * 32'd1000;
		hit = -1;
		stale_match = 1'b0;
		case (it.action)
			ACT_CHECK: begin
				// The first live match decides; expired matches are skipped
				// but remembered in case nothing live follows.
				for (int i = 0; i < CACHE_SLOTS && hit < 0; i++) begin
					if (slot_used[i] && slot_src[i] == it.source_node &&
							slot_id[i] == it.packet_ident) begin
						if (ttl_ms != 0 && (it.now_ms - slot_seen_ms[i]) > ttl_ms)
							stale_match = 1'b1;
						else
							hit = i;
					end
				end
				if (hit >= 0) begin
					if (it.upgrade_allowed && it.hops_left > slot_hops[hit]) begin
						slot_hops[hit] = it.hops_left;
						r.verdict = VERDICT_UPGRADE;
					end else begin
						dup_count = dup_count + 32'd1;
						r.verdict = VERDICT_SEEN;
					end
				end else begin
					// New packet: overwrite the oldest slot at the ring head.
					r.verdict = VERDICT_NEW;
					r.expired_match = stale_match;
					slot_used[ring_head] = 1'b1;
					slot_src[ring_head] = it.source_node;
					slot_id[ring_head] = it.packet_ident;
					slot_seen_ms[ring_head] = it.now_ms;
					slot_hops[ring_head] = it.hops_left;
					slot_relayed[ring_head] = 1'b0;
					slot_relay_ms[ring_head] = '0;
					ring_head = (ring_head + 1) % CACHE_SLOTS;
				end
			end
			ACT_MARK: begin
				s = find_entry(it.source_node, it.packet_ident);
				if (s >= 0) begin
					r.entry_found = 1'b1;
					slot_relayed[s] = 1'b1;
					slot_relay_ms[s] = it.now_ms;
				end
			end
			ACT_QUERY: begin
				s = find_entry(it.source_node, it.packet_ident);
				if (s >= 0) begin
					r.entry_found = 1'b1;
					if (slot_relayed[s]) begin
						r.was_relayed = 1'b1;
						r.relay_gap_ms = it.now_ms - slot_relay_ms[s];
					end
				end
			end
			default: begin
				// The unused code leaves the cache alone.
			end
		endcase
		r.duplicate_total = dup_count;
		return r;
	endfunction

	function automatic in_item_t make_item(input logic [1:0] act, input logic [31:0] src,
			input logic [31:0] id, input logic [2:0] hops, input logic upg,
			input logic [31:0] now);
		in_item_t it;
		it.action = act;
		it.source_node = src;
		it.packet_ident = id;
		it.hops_left = hops;
		it.upgrade_allowed = upg;
		it.now_ms = now;
		return it;
	endfunction

	// Mostly back-to-back or short gaps, now and then a long one, so that the
	// next start lands on every phase of a scan.
	function automatic int pick_gap(input bit burst);
		int roll;
		if (burst)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 95)
			return $urandom_range(4, 12);
		return $urandom_range(13, 45);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
	endtask

	// Sends one transaction. Called and returning at a falling edge; start is
	// left high so that a following call with no gap keeps it high.
	task automatic send_item(input in_item_t it, input int gap);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item = it;
		start = 1'b1;
		do @(posedge clk); while (busy);
		pending_verdicts.push_back(predict_verdict(it));
		@(negedge clk);
	endtask

	// Writes the lifetime register once every pending result has come back.
	// Every transaction produces a result, so an empty queue means idle.
	task automatic program_lifetime(input logic [15:0] seconds);
		start = 1'b0;
		do @(negedge clk); while (pending_verdicts.size() != 0);
		cfg_data = seconds;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		lifetime_s = seconds;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Result checker: each done strobe is matched against the oldest
	// expectation, field by field.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && done) begin
			if (pending_verdicts.size() == 0) begin
				report_mismatch("result with nothing pending, duplicate_total",
					result.duplicate_total, '0);
			end else begin
				want = pending_verdicts.pop_front();
				if (result.verdict !== want.verdict)
					report_mismatch("verdict", 32'(result.verdict), 32'(want.verdict));
				if (result.expired_match !== want.expired_match)
					report_mismatch("expired_match", 32'(result.expired_match),
						32'(want.expired_match));
				if (result.entry_found !== want.entry_found)
					report_mismatch("entry_found", 32'(result.entry_found),
						32'(want.entry_found));
				if (result.was_relayed !== want.was_relayed)
					report_mismatch("was_relayed", 32'(result.was_relayed),
						32'(want.was_relayed));
				if (result.relay_gap_ms !== want.relay_gap_ms)
					report_mismatch("relay_gap_ms", result.relay_gap_ms, want.relay_gap_ms);
				if (result.duplicate_total !== want.duplicate_total)
					report_mismatch("duplicate_total", result.duplicate_total,
						want.duplicate_total);
			end
		end
	end

	// Watchdog: any accepted transaction, result or register write counts as
	// progress. A hung block shows up as a long quiet stretch.
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("testbench: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Seen and upgrade verdicts, hop comparisons and the all-zero and all-one
	// keys, with expiry still off from reset.
	task automatic test_hit_and_upgrade();
		send_item(make_item(ACT_CHECK, 32'h0, 32'h0, 3'd0, 1'b0, 32'd0), pick_gap(0));
		send_item(make_item(ACT_CHECK, 32'h0, 32'h0, 3'd3, 1'b0, 32'd10), pick_gap(0));
		send_item(make_item(ACT_CHECK, 32'h0, 32'h0, 3'd5, 1'b1, 32'd20), pick_gap(0));
		// Equal and lower hop limits count as plain duplicates.
		send_item(make_item(ACT_CHECK, 32'h0, 32'h0, 3'd5, 1'b1, 32'd30), pick_gap(0));
		send_item(make_item(ACT_CHECK, 32'h0, 32'h0, 3'd2, 1'b1, 32'd40), pick_gap(0));
		send_item(make_item(ACT_CHECK, '1, '1, 3'd7, 1'b1, '1), pick_gap(0));
		send_item(make_item(ACT_CHECK, '1, '1, 3'd7, 1'b1, 32'd5), pick_gap(0));
		// Half-matching keys are different packets.
		send_item(make_item(ACT_CHECK, 32'h0, '1, 3'd1, 1'b0, 32'd6), pick_gap(0));
		send_item(make_item(ACT_CHECK, '1, 32'h0, 3'd1, 1'b0, 32'd7), pick_gap(0));
	endtask

	// Mark and query, with and without a matching slot, a relay gap that
	// wraps, and the unused action code.
	task automatic test_relay_marking();
		send_item(make_item(ACT_MARK, 32'h1234, 32'h5678, 3'd0, 1'b0, 32'd90), pick_gap(0));
		send_item(make_item(ACT_QUERY, 32'h1234, 32'h5678, 3'd0, 1'b0, 32'd91), pick_gap(0));
		send_item(make_item(ACT_MARK, 32'h0, 32'h0, 3'd0, 1'b0, 32'd100), pick_gap(0));
		send_item(make_item(ACT_QUERY, 32'h0, 32'h0, 3'd0, 1'b0, 32'd50), pick_gap(0));
		send_item(make_item(ACT_QUERY, '1, '1, 3'd0, 1'b0, 32'd7), pick_gap(0));
		send_item(make_item(ACT_UNUSED, 32'h0, 32'h0, 3'd7, 1'b1, 32'd8), pick_gap(0));
		send_item(make_item(ACT_QUERY, 32'h0, 32'h0, 3'd0, 1'b0, '1), pick_gap(0));
	endtask

	// One-second lifetime: the exact boundary, an expired match that leads to
	// a fresh insert, a later live copy hiding the expired one, and mark and
	// query that ignore expiry.
	task automatic test_expiry_window();
		program_lifetime(16'd1);
		send_item(make_item(ACT_CHECK, 32'hA5A5_0001, 32'h0BAD_F00D, 3'd2, 1'b0, 32'd5000),
			pick_gap(0));
		send_item(make_item(ACT_CHECK, 32'hA5A5_0001, 32'h0BAD_F00D, 3'd2, 1'b0, 32'd6000),
			pick_gap(0));
		send_item(make_item(ACT_CHECK, 32'hA5A5_0001, 32'h0BAD_F00D, 3'd2, 1'b0, 32'd6001),
			pick_gap(0));
		send_item(make_item(ACT_CHECK, 32'hA5A5_0001, 32'h0BAD_F00D, 3'd2, 1'b0, 32'd6500),
			pick_gap(0));
		send_item(make_item(ACT_MARK, 32'hA5A5_0001, 32'h0BAD_F00D, 3'd0, 1'b0, 32'd9000),
			pick_gap(0));
		send_item(make_item(ACT_QUERY, 32'hA5A5_0001, 32'h0BAD_F00D, 3'd0, 1'b0, 32'd9001),
			pick_gap(0));
		send_item(make_item(ACT_CHECK, 32'h0, 32'h0, 3'd7, 1'b1, 32'd3), pick_gap(0));
	endtask

	// Largest lifetime: 65535000 ms is still live, one more is expired.
	task automatic test_longest_lifetime();
		program_lifetime(16'hFFFF);
		send_item(make_item(ACT_CHECK, 32'h5A5A_7E7E, 32'h8000_0001, 3'd4, 1'b0, 32'd0),
			pick_gap(0));
		send_item(make_item(ACT_CHECK, 32'h5A5A_7E7E, 32'h8000_0001, 3'd4, 1'b0,
			32'd65535000), pick_gap(0));
		send_item(make_item(ACT_CHECK, 32'h5A5A_7E7E, 32'h8000_0001, 3'd4, 1'b0,
			32'd65535001), pick_gap(0));
	endtask

	// Random traffic over a small pool of keys, so that packets come back as
	// duplicates, get marked and queried, expire, and are pushed out of the
	// ring. The clock advances in steps scaled to the lifetime, with some
	// checks placed right at a slot's expiry boundary and a little noise.
	task automatic test_random_traffic(input logic [15:0] lifetime,
			input logic [31:0] clock_start);
		logic [31:0] pool_src [KEY_POOL];
		logic [31:0] pool_id [KEY_POOL];
		logic [31:0] ttl_ms;
		logic [31:0] clock_ms;
		in_item_t    it;
		int          roll;
		int          k;
		int          s;
		bit          burst;
		program_lifetime(lifetime);
		ttl_ms = 32'(lifetime) * 32'd1000;
		clock_ms = clock_start;
		burst = 1'b0;
		// Some keys share a source and some share an identifier, so that
		// a match needs both halves.
		for (int i = 0; i < KEY_POOL; i++) begin
			pool_src[i] = (i % 4 == 1) ? pool_src[i - 1] : 32'($urandom);
			pool_id[i] = (i % 4 == 3) ? pool_id[i - 1] : 32'($urandom);
		end
		for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
			if (n % 40 == 0)
				burst = ($urandom_range(0, 3) == 0);
			roll = $urandom_range(0, 99);
			k = $urandom_range(0, KEY_POOL - 1);
			it.source_node = pool_src[k];
			it.packet_ident = pool_id[k];
			if ($urandom_range(0, 19) == 0) begin
				it.source_node = $urandom;
				it.packet_ident = $urandom;
			end
			if (roll < 58)
				it.action = ACT_CHECK;
			else if (roll < 77)
				it.action = ACT_MARK;
			else if (roll < 96)
				it.action = ACT_QUERY;
			else
				it.action = ACT_UNUSED;
			it.hops_left = 3'($urandom_range(0, 7));
			it.upgrade_allowed = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 32) == 0)
				clock_ms = $urandom;
			else
				clock_ms = clock_ms + $urandom_range(0, (ttl_ms == 0) ? 2000 : ttl_ms / 16 + 1);
			it.now_ms = clock_ms;
			// Now and then probe one millisecond either side of expiry.
			if (it.action == ACT_CHECK && ttl_ms != 0 && $urandom_range(0, 9) == 0) begin
				s = find_entry(it.source_node, it.packet_ident);
				if (s >= 0)
					it.now_ms = slot_seen_ms[s] + ttl_ms + 32'($urandom_range(0, 2)) - 32'd1;
			end
			send_item(it, pick_gap(burst));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_hit_and_upgrade();
		test_relay_marking();
		test_expiry_window();
		test_longest_lifetime();
		test_random_traffic(16'd0, 32'd0);
		test_random_traffic(16'd1, 32'hFFFF_F000);
		test_random_traffic(16'd3, 32'($urandom));
		test_random_traffic(16'($urandom_range(1, 65535)), 32'($urandom));
		test_random_traffic(16'hFFFF, 32'($urandom));

		// Drain, then give a stray extra result time to show up.
		start = 1'b0;
		do @(negedge clk); while (pending_verdicts.size() != 0);
		repeat (40) @(negedge clk);
		if (mismatch_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hdl
hdl/pdc_pkg.sv
hdl/packet_duplicate_cache.sv
bench/testbench.sv
